FILE: rtl/core/npcl_pkg.sv
package npcl_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 8;
  localparam int WORD_W  = 32;
  localparam int RGB_W   = 3 * CHAN_W;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int SUM_W   = CHAN_W + 2;
  localparam int PROD_W  = 2 * SUM_W;

  localparam logic [WORD_W-1:0] EMPTY_CACHE = '1;
  localparam logic [DIST_W-1:0] DIST_MAX    = '1;
  localparam logic [CHAN_W-1:0] DIRECT_TAG  = 8'd1;

  // floor(s / 3) == (s * 683) >> 11 for every s up to 765
  localparam logic [SUM_W-1:0] RECIP_THIRD = 10'd683;
  localparam int RECIP_SHIFT = 11;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_LOADED  = 2'd1,
    OP_CONVERT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_LUMA   = 2'd1,
    SRC_CACHE  = 2'd2,
    SRC_SEARCH = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        entry_index;
    logic [7:0]        entry_red;
    logic [7:0]        entry_green;
    logic [7:0]        entry_blue;
    logic [WORD_W-1:0] colour_word;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] palette_index;
    logic [1:0]         source;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic take_fast;
    logic start_search;
    logic issue;
    logic take_best;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fast;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/npcl_ram.sv
module npcl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/npcl_dp.sv
module npcl_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  npcl_pkg::dp_cmd_t    cmd,
  output npcl_pkg::dp_status_t status,
  input  npcl_pkg::in_item_t   in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output npcl_pkg::out_item_t  out_data
);

  import npcl_pkg::*;

  // Held state
  logic                loaded_r;
  logic [WORD_W-1:0]   cache_colour_r;
  logic [INDEX_W-1:0]  cache_idx_r;
  logic [WORD_W-1:0]   colour_r;
  logic                entry_ok_r [PALETTE_ENTRIES];

  // Search pipeline
  logic [ADDR_W-1:0]   addr_r;
  logic                rd_v_r;
  logic [ADDR_W-1:0]   rd_idx_r;
  logic                rd_ok_r;
  logic                sq_v_r;
  logic [ADDR_W-1:0]   sq_idx_r;
  logic [SQ_W-1:0]     sq_r_r, sq_g_r, sq_b_r;
  logic [DIST_W-1:0]   best_d_r;
  logic [ADDR_W-1:0]   best_idx_r;

  // Result and output
  logic [INDEX_W-1:0]  res_idx_r;
  src_t                res_src_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                wr_en;
  logic [RGB_W-1:0]    ram_rdata;
  logic [RGB_W-1:0]    entry_rgb;
  logic [CHAN_W-1:0]   c_r, c_g, c_b, c_tag;
  logic [CHAN_W-1:0]   e_r, e_g, e_b;
  logic [CHAN_W-1:0]   d_r, d_g, d_b;
  logic [SUM_W-1:0]    lum_sum;
  logic [PROD_W-1:0]   lum_prod;
  logic [CHAN_W-1:0]   lum;
  logic                hit;
  logic [DIST_W-1:0]   dist_sum;
  logic [INDEX_W-1:0]  fast_idx;
  src_t                fast_src;

  assign wr_en = cmd.accept && (in_data.op == OP_WRITE) &&
                 (int'(in_data.entry_index) < PALETTE_ENTRIES);

  npcl_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.entry_index[ADDR_W-1:0]),
    .wr_data ({in_data.entry_red, in_data.entry_green, in_data.entry_blue}),
    .rd_en   (cmd.issue),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  assign c_r   = colour_r[7:0];
  assign c_g   = colour_r[15:8];
  assign c_b   = colour_r[23:16];
  assign c_tag = colour_r[31:24];

  // Fast paths
  assign lum_sum  = SUM_W'(c_r) + SUM_W'(c_g) + SUM_W'(c_b);
  assign lum_prod = PROD_W'(lum_sum) * PROD_W'(RECIP_THIRD);
  assign lum      = lum_prod[RECIP_SHIFT +: CHAN_W];
  assign hit      = (cache_colour_r != EMPTY_CACHE) && (colour_r == cache_colour_r);

  always_comb begin
    fast_idx = cache_idx_r;
    fast_src = SRC_CACHE;
    if (c_tag == DIRECT_TAG) begin
      fast_idx = c_r;
      fast_src = SRC_DIRECT;
    end else if (!loaded_r) begin
      fast_idx = lum;
      fast_src = SRC_LUMA;
    end
  end

  // An entry never written reads as black
  assign entry_rgb = rd_ok_r ? ram_rdata : '0;
  assign e_r = entry_rgb[2*CHAN_W +: CHAN_W];
  assign e_g = entry_rgb[CHAN_W +: CHAN_W];
  assign e_b = entry_rgb[0 +: CHAN_W];

  assign d_r = (c_r >= e_r) ? (c_r - e_r) : (e_r - c_r);
  assign d_g = (c_g >= e_g) ? (c_g - e_g) : (e_g - c_g);
  assign d_b = (c_b >= e_b) ? (c_b - e_b) : (e_b - c_b);

  assign dist_sum = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r       <= 1'b0;
      cache_colour_r <= EMPTY_CACHE;
      cache_idx_r    <= '0;
      rd_v_r         <= 1'b0;
      sq_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        entry_ok_r[i] <= 1'b0;
      end
    end else begin
      if (wr_en) begin
        entry_ok_r[in_data.entry_index[ADDR_W-1:0]] <= 1'b1;
        cache_colour_r <= EMPTY_CACHE;
      end
      if (cmd.accept && (in_data.op == OP_LOADED)) begin
        loaded_r       <= 1'b1;
        cache_colour_r <= EMPTY_CACHE;
      end
      // Cache the searched index unless the colour is the empty marker
      if (cmd.take_best && (colour_r != EMPTY_CACHE)) begin
        cache_colour_r <= colour_r;
        cache_idx_r    <= INDEX_W'(best_idx_r);
      end
      rd_v_r <= cmd.issue;
      sq_v_r <= rd_v_r;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      colour_r <= in_data.colour_word;
    end
    if (cmd.start_search) begin
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + ADDR_W'(1);
    end
    rd_idx_r <= addr_r;
    rd_ok_r  <= entry_ok_r[addr_r];
    sq_idx_r <= rd_idx_r;
    sq_r_r   <= SQ_W'(d_r) * SQ_W'(d_r);
    sq_g_r   <= SQ_W'(d_g) * SQ_W'(d_g);
    sq_b_r   <= SQ_W'(d_b) * SQ_W'(d_b);
    // Strict compare keeps the lowest index on a tie
    if (cmd.start_search) begin
      best_d_r   <= DIST_MAX;
      best_idx_r <= '0;
    end else if (sq_v_r && (dist_sum < best_d_r)) begin
      best_d_r   <= dist_sum;
      best_idx_r <= sq_idx_r;
    end
    if (cmd.take_fast) begin
      res_idx_r <= fast_idx;
      res_src_r <= fast_src;
    end else if (cmd.take_best) begin
      res_idx_r <= INDEX_W'(best_idx_r);
      res_src_r <= SRC_SEARCH;
    end
    if (cmd.load_out) begin
      out_data_r.palette_index <= res_idx_r;
      out_data_r.source        <= res_src_r;
    end
  end

  assign status.fast       = (c_tag == DIRECT_TAG) || !loaded_r || hit;
  assign status.last_issue = (addr_r == ADDR_W'(PALETTE_ENTRIES - 1));
  assign status.pipe_busy  = rd_v_r || sq_v_r;
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/npcl_ctrl.sv
module npcl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_op,
  output logic                 in_stall,
  input  npcl_pkg::dp_status_t status,
  output npcl_pkg::dp_cmd_t    cmd
);

  import npcl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && (in_op == OP_CONVERT)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.fast) begin
          cmd.take_fast = 1'b1;
          state_nxt     = ST_RESULT;
        end else begin
          cmd.start_search = 1'b1;
          state_nxt        = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last distance to reach the compare
        if (!status.pipe_busy) begin
          cmd.take_best = 1'b1;
          state_nxt     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/nearest_palette_colour_lookup.sv
// Channel  Ports                          Beat contents
// in       in_valid, in_stall, in_data    op, entry_index, entry_red/green/blue, colour_word
// out      out_valid, out_stall, out_data palette_index, source
//
// Palette writes and the loaded mark are taken in ST_IDLE, which they do not leave.
// A conversion answered by tag, luminance or cache goes from ST_CHECK to ST_RESULT, where
// it loads the output register; a search first reads every palette entry in ST_SEARCH,
// one palette RAM read per cycle through a read / square / compare pipeline, then drains.
// Synchronous active-low reset empties the palette (per-entry valid bits) and the cache.
// A waiting result holds in the output register under out_stall; the next beat is taken
// meanwhile, and a second result waits in the result register until the output frees.
module nearest_palette_colour_lookup (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  npcl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output npcl_pkg::out_item_t out_data
);

  import npcl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  npcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  npcl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: test/colour_index_checker.sv
module colour_index_checker
  import npcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatches,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [RGB_W-1:0]   palette_rgb [PALETTE_ENTRIES];
  logic               loaded;
  logic [WORD_W-1:0]  cached_word;
  logic [INDEX_W-1:0] cached_idx;
  out_item_t          expected_index_q [$];
  int                 error_count;

  // lowest index wins on equal distance
  function automatic logic [INDEX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] r,
                                                       input logic [CHAN_W-1:0] g,
                                                       input logic [CHAN_W-1:0] b);
    int best_d;
    int d;
    int dr;
    int dg;
    int db;
    logic [INDEX_W-1:0] best;
    best   = '0;
    best_d = 32'h7FFF_FFFF;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr = int'(r) - int'(palette_rgb[i][23:16]);
      dg = int'(g) - int'(palette_rgb[i][15:8]);
      db = int'(b) - int'(palette_rgb[i][7:0]);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best   = INDEX_W'(i);
      end
    end
    return best;
  endfunction

  function automatic bit predict_index(input in_item_t beat, output out_item_t res);
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    res = '0;
    r = beat.colour_word[7:0];
    g = beat.colour_word[15:8];
    b = beat.colour_word[23:16];
    case (beat.op)
      OP_WRITE: begin
        if (int'(beat.entry_index) < PALETTE_ENTRIES) begin
          palette_rgb[beat.entry_index] = {beat.entry_red, beat.entry_green, beat.entry_blue};
          cached_word = EMPTY_CACHE;
        end
        return 1'b0;
      end
      OP_LOADED: begin
        loaded      = 1'b1;
        cached_word = EMPTY_CACHE;
        return 1'b0;
      end
      OP_CONVERT: begin
        if (beat.colour_word[31:24] == DIRECT_TAG) begin
          res.palette_index = r;
          res.source        = SRC_DIRECT;
        end else if (!loaded) begin
          res.palette_index = INDEX_W'((int'(r) + int'(g) + int'(b)) / 3);
          res.source        = SRC_LUMA;
        end else if (cached_word != EMPTY_CACHE && beat.colour_word == cached_word) begin
          res.palette_index = cached_idx;
          res.source        = SRC_CACHE;
        end else begin
          res.palette_index = nearest_entry(r, g, b);
          res.source        = SRC_SEARCH;
          // all ones marks an empty cache, so never store it
          if (beat.colour_word != EMPTY_CACHE) begin
            cached_word = beat.colour_word;
            cached_idx  = res.palette_index;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) palette_rgb[i] = '0;
      loaded      = 1'b0;
      cached_word = EMPTY_CACHE;
      cached_idx  = '0;
      expected_index_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_index_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got index %0d source %0d",
                   $time, out_data.palette_index, out_data.source);
          error_count++;
        end else begin
          want = expected_index_q.pop_front();
          if (out_data.palette_index !== want.palette_index ||
              out_data.source !== want.source) begin
            if (out_data.palette_index !== want.palette_index)
              $display("%0t: palette_index mismatch, expected %0d, got %0d",
                       $time, want.palette_index, out_data.palette_index);
            if (out_data.source !== want.source)
              $display("%0t: source mismatch, expected %0d, got %0d",
                       $time, want.source, out_data.source);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (predict_index(in_data, want)) expected_index_q.push_back(want);
      end
    end
    mismatches <= error_count;
    pending    <= expected_index_q.size();
  end

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npcl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        mismatches;
  int        pending;

  logic [RGB_W-1:0]  written_rgb [PALETTE_ENTRIES];
  logic [WORD_W-1:0] last_word;
  int                counted_beats;
  int                sent_beats;
  int                taken_results;
  int                idle_cycles;
  bit                steady_in;
  bit                steady_out;

  nearest_palette_colour_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  colour_index_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t noise_beat();
    in_item_t beat;
    beat.op          = 2'($urandom);
    beat.entry_index = 8'($urandom);
    beat.entry_red   = 8'($urandom);
    beat.entry_green = 8'($urandom);
    beat.entry_blue  = 8'($urandom);
    beat.colour_word = $urandom;
    return beat;
  endfunction

  task automatic send_beat(input in_item_t beat);
    int gap;
    if (sent_beats % 50 == 0) steady_in = ($urandom_range(0, 3) == 0);
    gap = steady_in ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sent_beats++;
    if (beat.op != OP_UNUSED) counted_beats++;
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    in_item_t beat;
    beat             = noise_beat();
    beat.op          = OP_WRITE;
    beat.entry_index = idx;
    beat.entry_red   = r;
    beat.entry_green = g;
    beat.entry_blue  = b;
    written_rgb[idx] = {r, g, b};
    send_beat(beat);
  endtask

  task automatic send_convert(input logic [WORD_W-1:0] word);
    in_item_t beat;
    beat             = noise_beat();
    beat.op          = OP_CONVERT;
    beat.colour_word = word;
    last_word        = word;
    send_beat(beat);
  endtask

  task automatic send_op(input logic [1:0] op);
    in_item_t beat;
    beat    = noise_beat();
    beat.op = op;
    send_beat(beat);
  endtask

  task automatic send_random_write();
    send_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [WORD_W-1:0] pick_colour();
    logic [RGB_W-1:0]  rgb;
    logic [CHAN_W-1:0] tag;
    logic [1:0]        nudge;
    rgb   = written_rgb[$urandom_range(0, PALETTE_ENTRIES - 1)];
    tag   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
    nudge = 2'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return last_word;
      4, 5, 6: return {tag, rgb[7:0] ^ {6'd0, nudge}, rgb[15:8] ^ {7'd0, nudge[0]},
                       rgb[23:16] ^ {6'd0, nudge}};
      7:       return {8'd0, rgb[7:0], rgb[15:8], rgb[23:16]};
      8:       return {DIRECT_TAG, 24'($urandom)};
      default: return ($urandom_range(0, 1) == 0) ? EMPTY_CACHE : {8'hFF, 24'($urandom)};
    endcase
  endfunction

  initial begin
    logic [WORD_W-1:0] held;
    int kind;
    int start_count;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    last_word     = '0;
    counted_beats = 0;
    sent_beats    = 0;
    steady_in     = 1'b0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) written_rgb[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // luminance fallback, direct tag, an unused op and palette writes before the palette is loaded
    send_convert(32'h0000_0000);
    send_convert(32'h00FF_FFFF);
    send_convert(32'hFFFF_FFFF);
    send_convert(32'h00FE_FFFF);
    send_convert(32'h0000_0102);
    send_convert(32'h0100_00AB);
    send_convert(32'h01FF_FFFF);
    send_convert(32'h0200_0000);
    send_op(OP_UNUSED);
    send_write(8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_write(8'd1, 8'hFF, 8'h00, 8'h00);
    send_write(8'd128, 8'h00, 8'hFF, 8'h00);
    send_write(8'd2, 8'hFF, 8'h00, 8'h00);
    send_convert(32'h0000_00FF);
    // loaded: search, cache hit, tag change, clear on write, all-ones word, ties
    send_op(OP_LOADED);
    send_convert(32'h0000_00F0);
    send_convert(32'h0000_00F0);
    send_convert(32'h7F00_00F0);
    send_write(8'd3, 8'h10, 8'h10, 8'h10);
    send_convert(32'h7F00_00F0);
    send_convert(32'hFFFF_FFFF);
    send_convert(32'hFFFF_FFFF);
    send_convert(32'h0000_0000);
    send_op(OP_LOADED);
    send_op(OP_LOADED);
    send_convert(32'h0100_0005);
    send_convert(32'h0000_0000);

    start_count = counted_beats;
    while (counted_beats - start_count < RANDOM_BEATS) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        repeat ($urandom_range(1, 8)) send_random_write();
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 6)) send_convert(pick_colour());
      end else if (kind < 85) begin
        // a write between two equal colours clears the cache, so the second cannot be a cache hit
        held = pick_colour();
        send_convert(held);
        send_random_write();
        send_convert(held);
      end else if (kind < 90) begin
        send_op(OP_LOADED);
        send_convert(last_word);
      end else if (kind < 95) begin
        send_op(OP_UNUSED);
      end else begin
        held = pick_colour();
        send_convert(held);
        send_convert(held);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    int gap;
    out_stall     = 1'b0;
    taken_results = 0;
    steady_out    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken_results % 40 == 0) steady_out = ($urandom_range(0, 3) == 0);
      gap = steady_out ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken_results++;
    end
  end

endmodule

FILE: files.f
rtl/core/npcl_pkg.sv
rtl/core/npcl_ram.sv
rtl/core/npcl_dp.sv
rtl/core/npcl_ctrl.sv
rtl/core/nearest_palette_colour_lookup.sv
test/colour_index_checker.sv
test/tb.sv
